@@ hw/rtl/rks_pkg.sv @@
package rks_pkg;

  localparam int DEPTH  = 1024;
  localparam int AW     = $clog2(DEPTH);
  localparam int DW     = 32;
  localparam int CW     = AW + 1;

  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef logic signed [DW-1:0] val_t;
  typedef logic [AW-1:0]        addr_t;
  typedef logic [CW-1:0]        cnt_t;

  typedef struct packed {
    logic  start;
    logic  mode_count;   // 0: min/max pass, 1: count elements <= mid
    addr_t first;
    addr_t last;
    val_t  mid;
  } scan_ctl_t;

  typedef struct packed {
    logic done;
    val_t vmin;
    val_t vmax;
    cnt_t cnt;
  } scan_res_t;

endpackage

@@ hw/rtl/range_kth_smallest.sv @@
// channel  dir  tdata (low bit up)                                     tuser
// in_      in   load_value[31:0] first[41:32] last[51:42] rank[62:52]  cmd
// out_     out  kth_value[31:0]                                        status
// cfg_     in   cfg_wr_data = count_in_use[10:0], written on cfg_wr_en
//
// A load writes the value RAM and stays idle. Query: a min/max pass, then up to 32
// search rounds, each one pass over the range through the read port of the value
// RAM and the single scan unit; an error is answered without a pass.
// rst_n (synchronous) clears load position and control and sets count_in_use to 1024.
// in_tready is high only while idle; a result is held until out_tready.
module range_kth_smallest import rks_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  input  logic [63:0]   in_tdata,   // load_value, range_first, range_last, rank
  input  logic          in_tuser,   // cmd
  output logic          out_tvalid,
  input  logic          out_tready,
  output logic [31:0]   out_tdata,  // kth_value
  output logic          out_tuser,  // status
  input  logic          cfg_wr_en,
  input  logic [CW-1:0] cfg_wr_data
);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_MINMAX = 5'b00010,
    ST_SEARCH = 5'b00100,
    ST_COUNT  = 5'b01000,
    ST_DONE   = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  cnt_t   cfg_r;
  addr_t  pos_r, pos_nxt;
  addr_t  first_r, first_nxt;
  addr_t  last_r, last_nxt;
  cnt_t   k_r, k_nxt;
  val_t   lo_r, lo_nxt;
  val_t   hi_r, hi_nxt;
  val_t   mid_r, mid_nxt;
  val_t   res_val_r, res_val_nxt;
  logic   res_err_r, res_err_nxt;
  logic   out_vld_r, out_vld_nxt;
  val_t   out_val_r, out_val_nxt;
  logic   out_err_r, out_err_nxt;

  cnt_t      eff_cnt;
  addr_t     pos_eff;
  cnt_t      pos_inc;
  val_t      in_value;
  addr_t     in_first;
  addr_t     in_last;
  cnt_t      in_rank;
  cnt_t      q_len;
  logic      q_err;
  logic [DW:0] span;
  val_t      mid_c;
  logic      ram_we;
  addr_t     ram_raddr;
  val_t      ram_rdata;
  scan_ctl_t scan_ctl;
  scan_res_t scan_res;

  assign in_value = val_t'(in_tdata[31:0]);
  assign in_first = in_tdata[41:32];
  assign in_last  = in_tdata[51:42];
  assign in_rank  = in_tdata[62:52];

  assign eff_cnt = (cfg_r == '0) ? cnt_t'(1) :
                   (cfg_r > cnt_t'(DEPTH)) ? cnt_t'(DEPTH) : cfg_r;

  // a lowered count can leave the position past the end: restart at 0
  assign pos_eff = ({1'b0, pos_r} >= eff_cnt) ? '0 : pos_r;
  assign pos_inc = {1'b0, pos_eff} + cnt_t'(1);

  assign q_len = {1'b0, in_last} - {1'b0, in_first} + cnt_t'(1);
  assign q_err = (in_first > in_last) || ({1'b0, in_last} >= eff_cnt) ||
                 (in_rank == '0) || (in_rank > q_len);

  // hi > lo here, so the span is positive and half of it fits in DW bits
  assign span  = {hi_r[DW-1], hi_r} - {lo_r[DW-1], lo_r};
  assign mid_c = lo_r + val_t'(span[DW:1]);

  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    first_nxt   = first_r;
    last_nxt    = last_r;
    k_nxt       = k_r;
    lo_nxt      = lo_r;
    hi_nxt      = hi_r;
    mid_nxt     = mid_r;
    res_val_nxt = res_val_r;
    res_err_nxt = res_err_r;
    out_vld_nxt = out_vld_r;
    out_val_nxt = out_val_r;
    out_err_nxt = out_err_r;
    ram_we      = 1'b0;
    scan_ctl    = '0;

    if (out_tready) begin
      out_vld_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == CMD_LOAD) begin
            ram_we  = 1'b1;
            pos_nxt = (pos_inc >= eff_cnt) ? '0 : pos_inc[AW-1:0];
          end else begin
            first_nxt = in_first;
            last_nxt  = in_last;
            k_nxt     = in_rank;
            if (q_err) begin
              res_val_nxt = '0;
              res_err_nxt = STATUS_ERR;
              state_nxt   = ST_DONE;
            end else begin
              scan_ctl.start      = 1'b1;
              scan_ctl.mode_count = 1'b0;
              scan_ctl.first      = in_first;
              scan_ctl.last       = in_last;
              state_nxt           = ST_MINMAX;
            end
          end
        end
      end
      ST_MINMAX: begin
        if (scan_res.done) begin
          lo_nxt    = scan_res.vmin;
          hi_nxt    = scan_res.vmax;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (lo_r < hi_r) begin
          mid_nxt             = mid_c;
          scan_ctl.start      = 1'b1;
          scan_ctl.mode_count = 1'b1;
          scan_ctl.first      = first_r;
          scan_ctl.last       = last_r;
          scan_ctl.mid        = mid_c;
          state_nxt           = ST_COUNT;
        end else begin
          res_val_nxt = lo_r;
          res_err_nxt = STATUS_OK;
          state_nxt   = ST_DONE;
        end
      end
      ST_COUNT: begin
        if (scan_res.done) begin
          if (scan_res.cnt >= k_r) begin
            hi_nxt = mid_r;
          end else begin
            lo_nxt = mid_r + val_t'(1);
          end
          state_nxt = ST_SEARCH;
        end
      end
      ST_DONE: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt = 1'b1;
          out_val_nxt = res_val_r;
          out_err_nxt = res_err_r;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pos_r     <= '0;
      cfg_r     <= cnt_t'(DEPTH);
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      out_vld_r <= out_vld_nxt;
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
    end
    first_r   <= first_nxt;
    last_r    <= last_nxt;
    k_r       <= k_nxt;
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    mid_r     <= mid_nxt;
    res_val_r <= res_val_nxt;
    res_err_r <= res_err_nxt;
    out_val_r <= out_val_nxt;
    out_err_r <= out_err_nxt;
  end

  rks_ram #(
    .WIDTH (DW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (pos_eff),
    .wdata (in_value),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  rks_scan u_scan (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (scan_ctl),
    .raddr (ram_raddr),
    .rdata (ram_rdata),
    .res   (scan_res)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_val_r;
  assign out_tuser  = out_err_r;

endmodule

@@ hw/rtl/rks_ram.sv @@
module rks_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hw/rtl/rks_scan.sv @@
module rks_scan import rks_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  scan_ctl_t ctl,
  output addr_t     raddr,
  input  val_t      rdata,
  output scan_res_t res
);

  logic  busy_r, busy_nxt;
  addr_t addr_r, addr_nxt;
  addr_t last_r, last_nxt;
  logic  mode_r, mode_nxt;
  val_t  mid_r, mid_nxt;
  logic  rd_vld_r, rd_vld_nxt;
  logic  rd_last_r, rd_last_nxt;
  logic  have_r, have_nxt;
  val_t  vmin_r, vmin_nxt;
  val_t  vmax_r, vmax_nxt;
  cnt_t  cnt_r, cnt_nxt;
  logic  done_r, done_nxt;

  always_comb begin
    busy_nxt    = busy_r;
    addr_nxt    = addr_r;
    last_nxt    = last_r;
    mode_nxt    = mode_r;
    mid_nxt     = mid_r;
    rd_vld_nxt  = 1'b0;
    rd_last_nxt = 1'b0;
    have_nxt    = have_r;
    vmin_nxt    = vmin_r;
    vmax_nxt    = vmax_r;
    cnt_nxt     = cnt_r;
    done_nxt    = 1'b0;

    if (ctl.start) begin
      busy_nxt = 1'b1;
      addr_nxt = ctl.first;
      last_nxt = ctl.last;
      mode_nxt = ctl.mode_count;
      mid_nxt  = ctl.mid;
      have_nxt = 1'b0;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      rd_vld_nxt  = 1'b1;
      rd_last_nxt = (addr_r == last_r);
      if (addr_r == last_r) begin
        busy_nxt = 1'b0;
      end else begin
        addr_nxt = addr_r + addr_t'(1);
      end
    end

    // one element per cycle from the RAM read port, in the mode chosen at start
    if (rd_vld_r) begin
      if (mode_r) begin
        if (rdata <= mid_r) begin
          cnt_nxt = cnt_r + cnt_t'(1);
        end
      end else if (!have_r) begin
        have_nxt = 1'b1;
        vmin_nxt = rdata;
        vmax_nxt = rdata;
      end else begin
        if (rdata < vmin_r) vmin_nxt = rdata;
        if (rdata > vmax_r) vmax_nxt = rdata;
      end
      done_nxt = rd_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r    <= 1'b0;
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
      done_r    <= 1'b0;
    end else begin
      busy_r    <= busy_nxt;
      rd_vld_r  <= rd_vld_nxt;
      rd_last_r <= rd_last_nxt;
      done_r    <= done_nxt;
    end
    addr_r <= addr_nxt;
    last_r <= last_nxt;
    mode_r <= mode_nxt;
    mid_r  <= mid_nxt;
    have_r <= have_nxt;
    vmin_r <= vmin_nxt;
    vmax_r <= vmax_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign raddr    = addr_r;
  assign res.done = done_r;
  assign res.vmin = vmin_r;
  assign res.vmax = vmax_r;
  assign res.cnt  = cnt_r;

endmodule

@@ test/range_kth_smallest_tb.sv @@
module range_kth_smallest_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rks_pkg::*;

  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  localparam int unsigned DRAIN_CYCLES = 64;
  localparam int unsigned PHASE_ITEMS  = 11;
  localparam int unsigned MAX_REPORTS  = 10;

  typedef enum int unsigned {
    BAD_ORDER,
    BAD_LIMIT,
    BAD_RANK_ZERO,
    BAD_RANK_HIGH
  } bad_kind_t;

  typedef struct {
    val_t kth;
    logic status;
  } kth_result_t;

  // Mirrors the value store, load pointer and count register; predicts one
  // answer per query request.
  class kth_scoreboard;
    val_t        store [DEPTH];
    int unsigned load_pos;
    int unsigned count_reg;
    kth_result_t pending_q[$];
    int unsigned mismatches;
    int unsigned checked;
    int unsigned errors_seen;

    function new();
      load_pos    = 0;
      count_reg   = DEPTH;
      mismatches  = 0;
      checked     = 0;
      errors_seen = 0;
    endfunction

    function void set_count(cnt_t v);
      count_reg = v;
    endfunction

    function void note_request(logic [63:0] data, logic cmd);
      int unsigned cnt, first, last, rank, len, pos, n, i;
      longint      lo, hi, mid;
      kth_result_t r;
      cnt = (count_reg < 1) ? 1 : (count_reg > DEPTH) ? DEPTH : count_reg;
      if (cmd == CMD_LOAD) begin
        // pointer left past a lowered count restarts at position 0
        pos = (load_pos >= cnt) ? 0 : load_pos;
        store[pos] = data[31:0];
        load_pos = (pos + 1 >= cnt) ? 0 : pos + 1;
        return;
      end
      first    = data[41:32];
      last     = data[51:42];
      rank     = data[62:52];
      r.kth    = '0;
      r.status = STATUS_ERR;
      if (first <= last && last < cnt) begin
        len = last - first + 1;
        if (rank >= 1 && rank <= len) begin
          lo = store[first];
          hi = lo;
          for (i = first + 1; i <= last; i++) begin
            if (store[i] < lo) lo = store[i];
            if (store[i] > hi) hi = store[i];
          end
          // smallest v with at least rank elements <= v
          while (lo < hi) begin
            mid = lo + (hi - lo) / 2;
            n = 0;
            for (i = first; i <= last; i++)
              if (store[i] <= mid) n++;
            if (n >= rank) hi = mid;
            else lo = mid + 1;
          end
          r.kth    = lo[31:0];
          r.status = STATUS_OK;
        end
      end
      if (r.status == STATUS_ERR) errors_seen++;
      pending_q.push_back(r);
    endfunction

    function void check_result(val_t kth, logic status);
      kth_result_t e;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result: kth=%0d status=%0b", kth, status);
        return;
      end
      e = pending_q.pop_front();
      checked++;
      if (kth !== e.kth || status !== e.status) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("mismatch: expected kth=%0d status=%0b, got kth=%0d status=%0b",
                   e.kth, e.status, kth, status);
      end
    endfunction
  endclass

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [63:0]   in_tdata = '0;   // load_value, range_first, range_last, rank
  logic          in_tuser = 1'b0; // cmd
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [31:0]   out_tdata;       // kth_value
  logic          out_tuser;       // status
  logic          cfg_wr_en = 1'b0;
  cnt_t          cfg_wr_data = '0;

  kth_scoreboard sb = new();

  int unsigned phase_counts [7] = '{12, 1, 0, 2047, 6, 1024, 40};
  int unsigned stim_pos = 0;
  int unsigned stim_count = DEPTH;
  int unsigned written_top = 0;
  int unsigned n_loads = 0;
  int unsigned n_queries = 0;
  int unsigned n_settings = 0;
  int unsigned cycles = 0;
  bit          no_gaps = 1'b0;

  range_kth_smallest u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) sb.note_request(in_tdata, in_tuser);
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d answers outstanding",
               cycles, sb.pending_q.size());
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic int unsigned next_gap();
    return no_gaps ? 0 : $urandom_range(0, 7);
  endfunction

  function automatic val_t rand_value();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 8) - 4;  // small values, plenty of repeats
      1: return ($urandom_range(0, 1) == 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  task automatic send(logic cmd, val_t value, int unsigned first, int unsigned last,
                      int unsigned rank);
    int unsigned gap;
    gap = next_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tdata  <= {1'b0, rank[10:0], last[9:0], first[9:0], value};
    in_tuser  <= cmd;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic load_item(val_t v);
    int unsigned pos;
    pos = (stim_pos >= stim_count) ? 0 : stim_pos;
    if (pos + 1 > written_top) written_top = pos + 1;
    stim_pos = (pos + 1 >= stim_count) ? 0 : pos + 1;
    n_loads++;
    send(CMD_LOAD, v, $urandom, $urandom, $urandom);
  endtask

  task automatic query_item(int unsigned first, int unsigned last, int unsigned rank);
    n_queries++;
    send(CMD_QUERY, $urandom, first, last, rank);
  endtask

  // register write only with the block drained and idle
  task automatic set_count(int unsigned v);
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    while (!in_tready) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v[CW-1:0];
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_count(v[CW-1:0]);
    stim_count = (v < 1) ? 1 : (v > DEPTH) ? DEPTH : v;
    n_settings++;
  endtask

  // queries only touch positions loaded since reset
  task automatic random_item();
    int unsigned r, lim, first, last, len;
    bad_kind_t   kind;
    r   = $urandom_range(0, 99);
    lim = (written_top < stim_count) ? written_top : stim_count;
    if (r < 35 || lim == 0) begin
      load_item(rand_value());
      return;
    end
    first = $urandom_range(0, lim - 1);
    if ($urandom_range(0, 9) == 0) last = lim - 1;
    else last = $urandom_range(first, (first + 47 < lim) ? first + 47 : lim - 1);
    len = last - first + 1;
    if (r < 85) begin
      query_item(first, last, $urandom_range(1, len));
      return;
    end
    kind = bad_kind_t'($urandom_range(0, 3));
    if (kind == BAD_LIMIT && stim_count == DEPTH) kind = BAD_RANK_HIGH;
    case (kind)
      BAD_ORDER: begin
        first = $urandom_range(1, DEPTH - 1);
        query_item(first, $urandom_range(0, first - 1), $urandom_range(0, 2047));
      end
      BAD_LIMIT: begin
        last = $urandom_range(stim_count, DEPTH - 1);
        query_item($urandom_range(0, last), last, $urandom_range(0, 2047));
      end
      BAD_RANK_ZERO: query_item(first, last, 0);
      default: query_item(first, last, $urandom_range(len + 1, 2047));
    endcase
  endtask

  initial begin : out_ready_proc
    int unsigned gap;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      gap = next_gap();
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  initial begin : stimulus
    int unsigned phase, k;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    set_count(8);
    load_item(32'h8000_0000);
    load_item(32'h7FFF_FFFF);
    load_item(0);
    load_item(-1);
    load_item(5);
    load_item(5);
    load_item(5);
    load_item(-7);
    query_item(0, 7, 1);         // minimum
    query_item(0, 7, 8);         // maximum
    query_item(0, 7, 6);         // lands inside a run of repeats
    query_item(4, 6, 2);         // all equal
    query_item(3, 3, 1);         // single element
    query_item(5, 2, 1);         // first above last
    query_item(0, 8, 1);         // last past the count
    query_item(1023, 1023, 2047);
    query_item(0, 7, 0);         // rank zero
    query_item(2, 5, 5);         // rank above length

    // lowered count with the pointer beyond it: next load goes to 0
    set_count(16);
    load_item(rand_value());
    load_item(rand_value());
    load_item(rand_value());
    set_count(2);
    load_item(-32'sd3);
    query_item(0, 1, 2);

    for (phase = 0; phase < 7; phase++) begin
      no_gaps = phase[0];
      set_count(phase_counts[phase]);
      for (k = 0; k < PHASE_ITEMS; k++) random_item();
    end

    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("ran %0d loads and %0d queries (%0d rejected as bad range or rank)",
             n_loads, n_queries, sb.errors_seen);
    $display("over %0d count settings; %0d answers compared, %0d mismatches",
             n_settings, sb.checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
